/* sv/d2i_pkg.sv */
package d2i_pkg;

   localparam int FracW = 52;
   localparam int ExpW  = 11;
   localparam int MantW = FracW + 1;
   localparam int KW    = 6;
   // aligned operand: mantissa plus guard, round and sticky bits
   localparam int AlnW  = MantW + 3;
   localparam int SumW  = AlnW + 1;

   localparam logic [ExpW-1:0] ExpAllOnes = '1;
   localparam logic [ExpW-1:0] HalfBias   = 11'd1022;   // exponent field of 2^(k-1) minus k
   localparam logic [ExpW-1:0] RefBias    = 11'd1075;   // exponent field of 2^52 + 2^k scale

   typedef struct packed {
      logic [63:0] value_bits;
      logic        last;
   } req_type;

   typedef struct packed {
      logic signed [63:0] result;
      logic               last_out;
   } rsp_type;

   typedef struct packed {
      logic          valid;
      logic          neg;
      logic          special;   // infinity or NaN input
      logic          last;
      logic [KW-1:0] k;
   } ctl_type;

endpackage

/* sv/d2i_add.sv */
module d2i_add
   import d2i_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  req_type          in_item,
   input  logic [KW-1:0]    k,
   output ctl_type          out_ctl,
   output logic [ExpW-1:0]  out_exp,
   output logic [MantW-1:0] out_mant
);

   // stage A: unpack, pick the operand with the larger exponent
   ctl_type          a_ctl_ff, a_ctl_in;
   logic [ExpW-1:0]  a_exp_ff, a_exp_in;
   logic [MantW-1:0] a_big_ff, a_big_in;
   logic [MantW-1:0] a_small_ff, a_small_in;
   logic [ExpW-1:0]  a_dist_ff, a_dist_in;

   logic [ExpW-1:0]  ea, ea_eff, eb;
   logic [MantW-1:0] ma, mb;

   always_comb begin
      ea = in_item.value_bits[62:52];
      ea_eff = (ea == '0) ? ExpW'(1) : ea;
      ma = {ea != '0, in_item.value_bits[FracW-1:0]};
      eb = HalfBias + ExpW'(k);
      mb = {1'b1, {FracW{1'b0}}};
      a_ctl_in.valid   = in_valid;
      a_ctl_in.neg     = in_item.value_bits[63];
      a_ctl_in.special = (ea == ExpAllOnes);
      a_ctl_in.last    = in_item.last;
      a_ctl_in.k       = k;
      if (ea_eff >= eb) begin
         a_exp_in   = ea_eff;
         a_big_in   = ma;
         a_small_in = mb;
         a_dist_in  = ea_eff - eb;
      end else begin
         a_exp_in   = eb;
         a_big_in   = mb;
         a_small_in = ma;
         a_dist_in  = eb - ea_eff;
      end
   end

   // stage B: align the smaller operand and add
   ctl_type         b_ctl_ff;
   logic [ExpW-1:0] b_exp_ff;
   logic [SumW-1:0] b_sum_ff, b_sum_in;

   logic [AlnW-1:0] ext, mask, aligned;
   logic            lost;

   always_comb begin
      ext = {a_small_ff, 3'b000};
      if (a_dist_ff >= ExpW'(AlnW)) begin
         mask    = '0;
         lost    = |ext;
         aligned = '0;
      end else begin
         mask    = ~({AlnW{1'b1}} << a_dist_ff[5:0]);
         lost    = |(ext & mask);
         aligned = ext >> a_dist_ff[5:0];
      end
      aligned[0] = aligned[0] | lost;
      b_sum_in = {1'b0, a_big_ff, 3'b000} + {1'b0, aligned};
   end

   // stage C: normalize the carry and round to nearest even
   ctl_type          c_ctl_ff;
   logic [ExpW-1:0]  c_exp_ff, c_exp_in;
   logic [MantW-1:0] c_mant_ff, c_mant_in;

   logic             carry, g, st, up;
   logic [MantW-1:0] m;
   logic [MantW:0]   mr;
   logic [ExpW-1:0]  e;

   always_comb begin
      carry = b_sum_ff[SumW-1];
      m     = carry ? b_sum_ff[SumW-1:4] : b_sum_ff[SumW-2:3];
      g     = carry ? b_sum_ff[3] : b_sum_ff[2];
      st    = carry ? (|b_sum_ff[2:0]) : (|b_sum_ff[1:0]);
      e     = b_exp_ff + ExpW'(carry);
      up    = g & (st | m[0]);
      mr    = {1'b0, m} + (MantW+1)'(up);
      if (mr[MantW]) begin
         c_mant_in = mr[MantW:1];
         c_exp_in  = e + ExpW'(1);
      end else begin
         c_mant_in = mr[MantW-1:0];
         c_exp_in  = e;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff.valid <= 1'b0;
         b_ctl_ff.valid <= 1'b0;
         c_ctl_ff.valid <= 1'b0;
      end else if (enable) begin
         a_ctl_ff <= a_ctl_in;
         b_ctl_ff <= a_ctl_ff;
         c_ctl_ff <= b_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_exp_ff   <= a_exp_in;
         a_big_ff   <= a_big_in;
         a_small_ff <= a_small_in;
         a_dist_ff  <= a_dist_in;
         b_exp_ff   <= a_exp_ff;
         b_sum_ff   <= b_sum_in;
         c_exp_ff   <= c_exp_in;
         c_mant_ff  <= c_mant_in;
      end
   end

   assign out_ctl  = c_ctl_ff;
   assign out_exp  = c_exp_ff;
   assign out_mant = c_mant_ff;

endmodule

/* sv/double_to_int64_pow2_scaled_round_top.sv */
// An item accepted on req passes the registers of stages A, B, C, D and E before its result shows on rsp.
// Throughput: one item per cycle; the five-stage pipeline stalls as a whole
// only while a result waits on rsp without rsp_ready.
// Reset: synchronous, active high; clears all stage valid bits and sets the
// scale exponent k to 0.
module double_to_int64_pow2_scaled_round_top
   import d2i_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic [KW-1:0] csr_data
);

   // scale exponent k; divisor is 2^k
   logic [KW-1:0] k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else if (csr_valid) begin
         k_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;

   // whole pipe advances unless the output item is held
   logic enable;
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   // stages A..C: |x| + 2^(k-1) in binary64, round to nearest even
   ctl_type          c_ctl;
   logic [ExpW-1:0]  c_exp;
   logic [MantW-1:0] c_mant;

   d2i_add u_add (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (req_valid),
      .in_item  (req_data),
      .k        (k_ff),
      .out_ctl  (c_ctl),
      .out_exp  (c_exp),
      .out_mant (c_mant)
   );

   // stage D: shift the mantissa by exponent minus (1075 + k)
   ctl_type       d_ctl_ff;
   logic [63:0]   d_mag_ff, d_mag_in;
   logic [12:0]   dexp;
   logic [12:0]   rneg;

   always_comb begin
      dexp = {2'b00, c_exp} - {2'b00, RefBias + ExpW'(c_ctl.k)};
      rneg = 13'd0 - dexp;
      d_mag_in = '0;
      if (!dexp[12]) begin
         if (dexp < 13'd64) begin
            d_mag_in = {{(64-MantW){1'b0}}, c_mant} << dexp[5:0];
         end
      end else begin
         if (rneg < 13'd64) begin
            d_mag_in = {{(64-MantW){1'b0}}, c_mant} >> rneg[5:0];
         end
      end
   end

   // stage E: sign, special case and output register
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;

   always_comb begin
      rsp_in.last_out = d_ctl_ff.last;
      if (d_ctl_ff.special) begin
         rsp_in.result = '0;                   // infinity or NaN
      end else if (d_ctl_ff.neg) begin
         rsp_in.result = 64'sd0 - $signed(d_mag_ff);
      end else begin
         rsp_in.result = $signed(d_mag_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ctl_ff.valid <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else if (enable) begin
         d_ctl_ff     <= c_ctl;
         rsp_valid_ff <= d_ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         d_mag_ff <= d_mag_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // rounded sum is always normal, so its hidden bit is set
   a_hidden: assert property (@(posedge clock) disable iff (reset)
      c_ctl.valid && !c_ctl.special |-> c_mant[MantW-1])
      else $error("sum mantissa not normalized");

   // special inputs give a zero result
   a_special: assert property (@(posedge clock) disable iff (reset)
      enable && d_ctl_ff.valid && d_ctl_ff.special |=> rsp_data.result == 64'sd0)
      else $error("special input gave nonzero result");

   // an item in the last adder stage moves on when the pipe advances
   a_advance: assert property (@(posedge clock) disable iff (reset)
      enable && c_ctl.valid |=> d_ctl_ff.valid)
      else $error("item lost between stages");

endmodule
